/* sv/mpbe_pkg.sv */
// Shared constants, types and the exp2 fraction table of the modified Phong BRDF evaluator.
package mpbe_pkg;

    localparam int          ZERO_EPS_Q16 = 7;
    localparam logic [30:0] INV_PI_Q32   = 31'd1367130551;
    localparam logic [29:0] INV_2PI_Q32  = 30'd683565276;
    localparam logic [23:0] OUT_MAX      = 24'hFFFFFF;
    localparam logic [47:0] POW_CAP      = 48'h8000_0000_0000;
    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;

    typedef enum logic [2:0] {
        REG_DIFFUSE_RED,
        REG_DIFFUSE_GREEN,
        REG_DIFFUSE_BLUE,
        REG_SPECULAR_RED,
        REG_SPECULAR_GREEN,
        REG_SPECULAR_BLUE,
        REG_SHININESS
    } cfg_reg_t;

    // per-item flags and diffuse density that ride along the pipeline
    typedef struct packed {
        logic        zero;
        logic        spec;
        logic [23:0] dens0;
    } side_t;

    // 2^(2^-(k+1)) in Q30
    function automatic logic [30:0] exp2_frac(input logic [3:0] k);
        logic [30:0] v;
        case (k)
            4'd0:    v = 31'd1518500250;
            4'd1:    v = 31'd1276901417;
            4'd2:    v = 31'd1170923762;
            4'd3:    v = 31'd1121280436;
            4'd4:    v = 31'd1097253708;
            4'd5:    v = 31'd1085434106;
            4'd6:    v = 31'd1079572136;
            4'd7:    v = 31'd1076653033;
            4'd8:    v = 31'd1075196443;
            4'd9:    v = 31'd1074468888;
            4'd10:   v = 31'd1074105294;
            4'd11:   v = 31'd1073923544;
            4'd12:   v = 31'd1073832684;
            4'd13:   v = 31'd1073787251;
            4'd14:   v = 31'd1073764537;
            4'd15:   v = 31'd1073753181;
            default: v = ONE_Q30;
        endcase
        return v;
    endfunction

endpackage

/* sv/modified_phong_brdf_eval_core.sv */
// Top level: fully pipelined modified Phong BRDF and sampling density evaluator.
//
// Usage:
//  - s_ channel: one transaction carries normal, outgoing and incoming directions,
//    nine signed fixed-point components. m_ channel: one transaction per input,
//    red, green, blue BRDF and the sampling density, unsigned Q8.16, saturated.
//  - cfg port: write kd/ks per channel and the shininess only while idle. Each
//    write to a valid register address starts a weight update (two 16-step
//    restoring dividers plus coefficient settle) during which s_tready is low.
//  - Throughput: one transaction per clock unless a weight update or a full skid
//    register holds s_tready low. Depth: 16 log2 squaring and 16 exp2 multiply
//    stages, one 31x31 multiplier each, plus dot, normalize and scale stages.
//  - Stall: the whole pipeline advances together; a skid register behind the
//    output register catches the one result that arrives while m_tready is low,
//    so back-pressure drops s_tready only once that skid register is occupied.
//  - Reset (aresetn low, synchronous): registers and weights clear to zero, the
//    pipeline and output are emptied, nothing is lost or repeated after that.
module modified_phong_brdf_eval_core #(
    parameter int VECTOR_FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // normal_x/y/z, out_dir_x/y/z, in_dir_x/y/z, 16 bits each, from bit 0 up
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // reflect_red, reflect_green, reflect_blue, sample_density, 24 bits each
    output logic [95:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);
    import mpbe_pkg::*;

    localparam int DOT_SHIFT = 2 * VECTOR_FRAC_BITS - 16;
    localparam int DW   = (DOT_SHIFT <= 29) ? 34 - DOT_SHIFT : 5; // dot product width
    localparam int CW   = 2 * DW + 1;                             // cosine width
    localparam int NCH  = (CW + 7) / 8;                           // leading-one chunks
    localparam int LW   = NCH * 8;
    localparam int PW   = $clog2(LW);
    localparam int LGH  = PW + 2;                                 // integer part of log2
    localparam int LGW  = LGH + 16;
    localparam int EW   = LGW + 17;                               // shininess * log2
    localparam int DAW  = 16 + DW;
    localparam int DBW  = DW + 32;
    localparam int NST  = 44;
    localparam logic [4:0] BUSY_LOAD    = 5'd21;
    localparam logic [4:0] BUSY_WEIGHTS = 5'd4;

    // ---------------- configuration and derived weights ----------------
    logic [15:0] kd_reg [3];
    logic [15:0] ks_reg [3];
    logic [15:0] shin_reg;
    logic [4:0]  busy_reg;
    logic [17:0] rd_reg, rs_reg;
    logic [16:0] tot_reg;
    logic [15:0] qd_reg, qs_reg;
    logic [15:0] dw_reg, sw_reg;
    logic [15:0] md, ms;
    logic        cfg_hit;

    always_comb begin
        md = (kd_reg[0] > kd_reg[1]) ? kd_reg[0] : kd_reg[1];
        md = (md > kd_reg[2]) ? md : kd_reg[2];
        ms = (ks_reg[0] > ks_reg[1]) ? ks_reg[0] : ks_reg[1];
        ms = (ms > ks_reg[2]) ? ms : ks_reg[2];
    end

    always_comb begin
        cfg_hit = 1'b1;
        case (cfg_reg_t'(cfg_addr))
            REG_DIFFUSE_RED, REG_DIFFUSE_GREEN, REG_DIFFUSE_BLUE,
            REG_SPECULAR_RED, REG_SPECULAR_GREEN, REG_SPECULAR_BLUE,
            REG_SHININESS: cfg_hit = 1'b1;
            default:       cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                kd_reg[i] <= '0;
                ks_reg[i] <= '0;
            end
            shin_reg <= '0;
            busy_reg <= '0;
            dw_reg   <= '0;
            sw_reg   <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_DIFFUSE_RED:    kd_reg[0] <= cfg_wdata;
                    REG_DIFFUSE_GREEN:  kd_reg[1] <= cfg_wdata;
                    REG_DIFFUSE_BLUE:   kd_reg[2] <= cfg_wdata;
                    REG_SPECULAR_RED:   ks_reg[0] <= cfg_wdata;
                    REG_SPECULAR_GREEN: ks_reg[1] <= cfg_wdata;
                    REG_SPECULAR_BLUE:  ks_reg[2] <= cfg_wdata;
                    REG_SHININESS:      shin_reg  <= cfg_wdata;
                    default:            ;
                endcase
            end
            if (cfg_we && cfg_hit) begin
                busy_reg <= BUSY_LOAD;
            end else if (busy_reg != '0) begin
                busy_reg <= busy_reg - 5'd1;
            end
            if (busy_reg == BUSY_WEIGHTS) begin
                dw_reg <= (tot_reg == '0) ? '0 : qd_reg;
                sw_reg <= (tot_reg == '0) ? '0 : qs_reg;
            end
        end
    end

    // restoring dividers: weight = floor(32768 * max / (md + ms))
    always_ff @(posedge aclk) begin
        if (busy_reg == BUSY_LOAD) begin
            rd_reg  <= 18'(md);
            rs_reg  <= 18'(ms);
            tot_reg <= 17'(md) + 17'(ms);
            qd_reg  <= '0;
            qs_reg  <= '0;
        end else if (busy_reg > BUSY_WEIGHTS) begin
            if (rd_reg >= 18'(tot_reg)) begin
                qd_reg <= {qd_reg[14:0], 1'b1};
                rd_reg <= 18'(rd_reg - 18'(tot_reg)) << 1;
            end else begin
                qd_reg <= {qd_reg[14:0], 1'b0};
                rd_reg <= rd_reg << 1;
            end
            if (rs_reg >= 18'(tot_reg)) begin
                qs_reg <= {qs_reg[14:0], 1'b1};
                rs_reg <= 18'(rs_reg - 18'(tot_reg)) << 1;
            end else begin
                qs_reg <= {qs_reg[14:0], 1'b0};
                rs_reg <= rs_reg << 1;
            end
        end
    end

    // coefficients follow the registers continuously: ca_reg/da_reg then coef_reg, and diff_reg
    logic [32:0] ca_reg [3];
    logic [32:0] da_reg;
    logic [33:0] coef_reg [4];  // specular red, green, blue, density
    logic [14:0] diff_reg [3];

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            ca_reg[c]   <= 33'(ks_reg[c]) * (33'(shin_reg) + 33'd128);
            coef_reg[c] <= 34'((63'(ca_reg[c]) * 63'(INV_2PI_Q32)) >> 30);
            diff_reg[c] <= 15'((47'(kd_reg[c]) * 47'(INV_PI_Q32)) >> 32);
        end
        da_reg      <= 33'(sw_reg) * (33'(shin_reg) + 33'd64);
        coef_reg[3] <= 34'((64'(da_reg) * 64'(INV_2PI_Q32)) >> 29);
    end

    // ---------------- handshake ----------------
    logic              en, in_acc;
    logic [NST:1]      vld_reg;
    logic [95:0]       fin_reg, out_reg, skid_reg;
    logic              out_vld_reg, skid_vld_reg;

    assign en       = !skid_vld_reg;
    assign s_tready = !skid_vld_reg && (busy_reg == '0);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-1:1], in_acc};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_tready) begin
            if (skid_vld_reg) begin
                out_reg      <= skid_reg;
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_reg     <= fin_reg;
                out_vld_reg <= vld_reg[NST];
            end
        end else if (en && vld_reg[NST]) begin
            skid_reg     <= fin_reg;
            skid_vld_reg <= 1'b1;
        end
    end

    // ---------------- datapath combinational pieces ----------------
    logic signed [15:0] nv [3];
    logic signed [15:0] wo [3];
    logic signed [15:0] wi [3];
    logic signed [31:0] pr_reg [9];  // wi.n, wo.n, wo.wi terms
    logic signed [33:0] sum_wn, sum_on, sum_oi;
    logic signed [DW-1:0] dwn_reg, don_reg, dwo_reg, dwo3_reg;
    logic signed [2*DW-1:0] dd_reg;
    logic               zero3_reg;
    logic [DAW-1:0]     densa_reg;
    logic signed [CW-1:0] cosv;
    logic               spec4;
    logic [LW-1:0]      c4_reg, c5_reg, c6_reg;
    logic [DBW-1:0]     densb_reg, dens_sh;
    logic [23:0]        dens_sat;
    logic [NCH-1:0]     nz;
    logic [2:0]         pos [NCH];
    logic [NCH-1:0]     nz5_reg;
    logic [2:0]         pos5_reg [NCH];
    logic [PW-1:0]      p_sel, p6_reg;
    logic [63:0]        cx;
    logic [30:0]        m_norm;
    side_t              side_reg [4:43];
    logic [30:0]        lm_reg [17];
    logic [15:0]        lf_reg [17];
    logic [PW-1:0]      lp_reg [17];
    logic [61:0]        lsq [16];
    logic signed [LGH-1:0] lg_hi;
    logic signed [LGW-1:0] lg;
    logic signed [EW-1:0]  prod_reg;
    logic [30:0]        em_reg [17];
    logic [15:0]        ef_reg [17];
    logic signed [EW-1:0] eti_reg [17];
    logic [61:0]        ep [16];
    logic signed [EW-1:0] ti;
    logic [47:0]        pw, pw_reg;
    logic [57:0]        lo_reg [4];
    logic [57:0]        hi_reg [4];
    logic [58:0]        sval [4];
    logic [23:0]        sp [4];
    logic [24:0]        acc [4];
    logic [23:0]        res [4];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nv[i] = s_tdata[16*i +: 16];
            wo[i] = s_tdata[48 + 16*i +: 16];
            wi[i] = s_tdata[96 + 16*i +: 16];
        end
        sum_wn = 34'(pr_reg[0]) + 34'(pr_reg[1]) + 34'(pr_reg[2]);
        sum_on = 34'(pr_reg[3]) + 34'(pr_reg[4]) + 34'(pr_reg[5]);
        sum_oi = 34'(pr_reg[6]) + 34'(pr_reg[7]) + 34'(pr_reg[8]);
        // mirrored cosine: floor(2*(n.wi)*(n.wo)/2^16) - wo.wi
        cosv  = ((CW'(dd_reg) <<< 1) >>> 16) - CW'(dwo3_reg);
        spec4 = !zero3_reg && (cosv > 0);
        dens_sh  = densb_reg >> 32;
        dens_sat = (dens_sh > DBW'(OUT_MAX)) ? OUT_MAX : dens_sh[23:0];
        // leading one, chunk by chunk
        for (int ch = 0; ch < NCH; ch++) begin
            nz[ch]  = |c4_reg[ch*8 +: 8];
            pos[ch] = '0;
            for (int b = 0; b < 8; b++) begin
                if (c4_reg[ch*8 + b]) pos[ch] = 3'(b);
            end
        end
        p_sel = '0;
        for (int ch = 0; ch < NCH; ch++) begin
            if (nz5_reg[ch]) p_sel = PW'(ch * 8) + PW'(pos5_reg[ch]);
        end
        cx     = 64'(c6_reg);
        m_norm = (p6_reg >= PW'(30)) ? 31'(cx >> (p6_reg - PW'(30)))
                                     : 31'(cx << (PW'(30) - p6_reg));
        for (int k = 0; k < 16; k++) begin
            lsq[k] = 62'(lm_reg[k]) * 62'(lm_reg[k]);
            ep[k]  = 62'(em_reg[k]) * 62'(exp2_frac(4'(k)));
        end
        lg_hi = $signed(LGH'(lp_reg[16])) - $signed(LGH'(16));
        lg    = {lg_hi, lf_reg[16]};
        ti    = eti_reg[16];
        if (ti >= 31) begin
            pw = POW_CAP;
        end else if (ti >= 14) begin
            pw = 48'(em_reg[16]) << 5'(ti - 14);
        end else if (ti <= -17) begin
            pw = '0;
        end else begin
            pw = 48'(em_reg[16]) >> 5'(14 - ti);
        end
        // specular products: hi*2^24 + lo, then >> 24 and saturate
        for (int c = 0; c < 4; c++) begin
            sval[c] = 59'(hi_reg[c]) + 59'(lo_reg[c] >> 24);
            sp[c]   = !side_reg[43].spec ? '0
                    : (sval[c] > 59'(OUT_MAX)) ? OUT_MAX : sval[c][23:0];
            acc[c]  = (c < 3) ? 25'(diff_reg[c % 3]) + 25'(sp[c])
                              : 25'(side_reg[43].dens0) + 25'(sp[c]);
            res[c]  = side_reg[43].zero ? '0
                    : (acc[c] > 25'(OUT_MAX)) ? OUT_MAX : acc[c][23:0];
        end
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: nine products
            for (int i = 0; i < 3; i++) begin
                pr_reg[i]     <= wi[i] * nv[i];
                pr_reg[3 + i] <= wo[i] * nv[i];
                pr_reg[6 + i] <= wo[i] * wi[i];
            end
            // stage 2: dot products in Q.16
            dwn_reg <= DW'(sum_wn >>> DOT_SHIFT);
            don_reg <= DW'(sum_on >>> DOT_SHIFT);
            dwo_reg <= DW'(sum_oi >>> DOT_SHIFT);
            // stage 3
            dd_reg    <= dwn_reg * don_reg;
            dwo3_reg  <= dwo_reg;
            zero3_reg <= (dwn_reg <= $signed(DW'(ZERO_EPS_Q16)))
                      || (don_reg <= $signed(DW'(ZERO_EPS_Q16)));
            densa_reg <= DAW'(dw_reg) * DAW'($unsigned(dwn_reg));
            // stage 4
            side_reg[4] <= '{zero: zero3_reg, spec: spec4, dens0: '0};
            c4_reg      <= spec4 ? LW'($unsigned(cosv)) : LW'(1);
            densb_reg   <= DBW'(densa_reg >> 15) * DBW'(INV_PI_Q32);
            // stage 5
            side_reg[5] <= '{zero: side_reg[4].zero, spec: side_reg[4].spec,
                             dens0: dens_sat};
            nz5_reg <= nz;
            for (int ch = 0; ch < NCH; ch++) pos5_reg[ch] <= pos[ch];
            c5_reg  <= c4_reg;
            // stage 6
            p6_reg <= p_sel;
            c6_reg <= c5_reg;
            // stage 7: mantissa in [1, 2) Q30
            lm_reg[0] <= m_norm;
            lf_reg[0] <= '0;
            lp_reg[0] <= p6_reg;
            // stages 8..23: one log2 fraction bit per squaring
            for (int k = 0; k < 16; k++) begin
                if (lsq[k][61]) begin
                    lm_reg[k + 1] <= lsq[k][61:31];
                    lf_reg[k + 1] <= lf_reg[k] | (16'h8000 >> k);
                end else begin
                    lm_reg[k + 1] <= lsq[k][60:30];
                    lf_reg[k + 1] <= lf_reg[k];
                end
                lp_reg[k + 1] <= lp_reg[k];
            end
            // stage 24: shininess * log2
            prod_reg <= $signed({1'b0, shin_reg}) * lg;
            // stage 25: split into integer and fraction (Q10.6 shift folded in)
            em_reg[0]  <= ONE_Q30;
            ef_reg[0]  <= prod_reg[21:6];
            eti_reg[0] <= prod_reg >>> 22;
            // stages 26..41: exp2 of the fraction, one bit each
            for (int k = 0; k < 16; k++) begin
                em_reg[k + 1]  <= ef_reg[k][15 - k] ? ep[k][60:30] : em_reg[k];
                ef_reg[k + 1]  <= ef_reg[k];
                eti_reg[k + 1] <= eti_reg[k];
            end
            // stage 42
            pw_reg <= pw;
            // stage 43: partial products
            for (int c = 0; c < 4; c++) begin
                lo_reg[c] <= 58'(coef_reg[c]) * 58'(pw_reg[23:0]);
                hi_reg[c] <= 58'(coef_reg[c]) * 58'(pw_reg[47:24]);
            end
            // stage 44
            fin_reg <= {res[3], res[2], res[1], res[0]};
            for (int k = 6; k < 44; k++) side_reg[k] <= side_reg[k - 1];
        end
    end

endmodule

/* sv/mpbe_checker.sv */
// Port-level checker for the BRDF evaluator and its bind to the top level.
module mpbe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        cfg_we,
    input logic [2:0]  cfg_addr
);
    import mpbe_pkg::*;

    // reset empties the output side
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a register write blocks input while weights are recomputed
    a_cfg_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_we && (cfg_addr <= 3'(REG_SHININESS))) |=> !s_tready)
        else $error("input accepted during weight update");

    // held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind modified_phong_brdf_eval_core mpbe_checker u_mpbe_checker (.*);

/* bench/tb.sv */
// Self-checking testbench for modified_phong_brdf_eval_core with a built-in predictor.
`timescale 1ns / 1ps

module tb;
    import mpbe_pkg::*;

    localparam int          LATENCY_WAIT = 60;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [2:0]  REG_UNUSED   = 3'd7;   // index past the register map
    localparam longint      BELOW_EPS    = 7;      // cosine floor, Q.16
    localparam longint unsigned SAT24    = 64'hFFFFFF;

    typedef struct {
        logic signed [15:0] nrm [3];
        logic signed [15:0] wo  [3];
        logic signed [15:0] wi  [3];
    } ray_t;

    typedef struct {
        logic [23:0] red;
        logic [23:0] green;
        logic [23:0] blue;
        logic [23:0] dens;
    } shade_t;

    // 2^(2^-(k+1)) in Q30, used by the exp2 fraction steps
    localparam longint unsigned EXP2_STEP [16] = '{
        1518500250, 1276901417, 1170923762, 1121280436,
        1097253708, 1085434106, 1079572136, 1076653033,
        1075196443, 1074468888, 1074105294, 1073923544,
        1073832684, 1073787251, 1073764537, 1073753181
    };

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [15:0]  cfg_wdata = '0;

    always #1 aclk = ~aclk;

    modified_phong_brdf_eval_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // shadow copy of the material registers and derived pdf weights
    longint unsigned kd [3];
    longint unsigned ks [3];
    longint unsigned shine;
    longint unsigned w_diff, w_spec;

    shade_t shade_q [$];
    int     n_fail;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_req;

    function automatic longint unsigned max3(longint unsigned a, b, c);
        longint unsigned m;
        m = a > b ? a : b;
        return m > c ? m : c;
    endfunction

    function automatic void refresh_weights();
        longint unsigned md, ms;
        md = max3(kd[0], kd[1], kd[2]);
        ms = max3(ks[0], ks[1], ks[2]);
        if (md + ms == 0) begin
            w_diff = 0;
            w_spec = 0;
        end else begin
            w_diff = (md * 32768) / (md + ms);
            w_spec = (ms * 32768) / (md + ms);
        end
    endfunction

    // exact dot product floored to Q.16
    function automatic longint dot16(logic signed [15:0] a [3], logic signed [15:0] b [3]);
        longint raw;
        raw = longint'(a[0]) * b[0] + longint'(a[1]) * b[1] + longint'(a[2]) * b[2];
        return raw >>> 12;
    endfunction

    // c^expo via bitwise log2 / exp2; c > 0 in Q.16, expo Q10.6
    function automatic longint unsigned lobe_pow(longint unsigned c, longint unsigned expo);
        int              p;
        longint unsigned m, f, frac;
        longint          lg, t, ti;
        p = 63;
        while (p > 0 && c[p] == 1'b0) p--;
        m = (p >= 30) ? (c >> (p - 30)) : (c << (30 - p));
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | (64'd1 << (15 - i));
            end
        end
        lg = longint'(p - 16) * 65536 + longint'(frac);
        t  = (longint'(expo) * lg) >>> 6;
        ti = t >>> 16;
        f  = $unsigned(t - ti * 65536);
        m  = 64'd1 << 30;
        for (int i = 0; i < 16; i++)
            if (f[15 - i]) m = (m * EXP2_STEP[i]) >> 30;
        if (ti >= 31) return 64'd1 << 47;
        if (ti >= 14) return m << (ti - 14);
        if (14 - ti >= 63) return 0;
        return m >> (14 - ti);
    endfunction

    function automatic longint unsigned scale_sat(longint unsigned coef, longint unsigned pw);
        longint unsigned r;
        if (coef == 0 || pw == 0) return 0;
        if (pw > 64'hFFFF_FFFF_FFFF_FFFF / coef) return SAT24;
        r = (coef * pw) >> 24;
        return r > SAT24 ? SAT24 : r;
    endfunction

    function automatic longint unsigned add_sat(longint unsigned a, b);
        return (a + b > SAT24) ? SAT24 : a + b;
    endfunction

    function automatic shade_t predict_shade(ray_t r);
        shade_t          o;
        longint          d_in, d_out, d_io, cos_a;
        longint unsigned pw, dens, coef, ch [3];
        logic            lobe;
        o = '{default: '0};
        d_in  = dot16(r.wi, r.nrm);
        d_out = dot16(r.wo, r.nrm);
        d_io  = dot16(r.wo, r.wi);
        if (d_in <= BELOW_EPS || d_out <= BELOW_EPS) return o;
        cos_a = longint'((64'd2 * d_in * d_out) >> 16) - d_io;
        lobe  = cos_a > 0;
        pw    = lobe ? lobe_pow($unsigned(cos_a), shine) : 0;
        for (int i = 0; i < 3; i++) begin
            ch[i] = (kd[i] * INV_PI_Q32) >> 32;
            if (lobe) begin
                coef  = (ks[i] * (shine + 128) * INV_2PI_Q32) >> 30;
                ch[i] = add_sat(ch[i], scale_sat(coef, pw));
            end else begin
                ch[i] = add_sat(ch[i], 0);
            end
        end
        dens = (((w_diff * $unsigned(d_in)) >> 15) * INV_PI_Q32) >> 32;
        if (dens > SAT24) dens = SAT24;
        if (lobe) begin
            coef = (w_spec * (shine + 64) * INV_2PI_Q32) >> 29;
            dens = add_sat(dens, scale_sat(coef, pw));
        end
        o.red   = 24'(ch[0]);
        o.green = 24'(ch[1]);
        o.blue  = 24'(ch[2]);
        o.dens  = 24'(dens);
        return o;
    endfunction

    // ---------------- stimulus side ----------------

    // one input transaction; s_tvalid stays high unless an idle gap follows
    task automatic send_ray(ray_t r);
        logic [143:0] v;
        for (int i = 0; i < 3; i++) begin
            v[16*i +: 16]      = r.nrm[i];
            v[48 + 16*i +: 16] = r.wo[i];
            v[96 + 16*i +: 16] = r.wi[i];
        end
        s_tdata  <= v;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        shade_q.push_back(predict_shade(r));
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (shade_q.size() != 0) @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    // write one material register; keeps the shadow copy in step
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DIFFUSE_RED:    kd[0] = val;
            REG_DIFFUSE_GREEN:  kd[1] = val;
            REG_DIFFUSE_BLUE:   kd[2] = val;
            REG_SPECULAR_RED:   ks[0] = val;
            REG_SPECULAR_GREEN: ks[1] = val;
            REG_SPECULAR_BLUE:  ks[2] = val;
            REG_SHININESS:      shine = val;
            default: ;   // out of range, ignored
        endcase
        if (idx <= REG_SHININESS) refresh_weights();
        @(posedge aclk);
    endtask

    task automatic load_material(logic [15:0] d [3], logic [15:0] sp [3], logic [15:0] n);
        write_reg(REG_DIFFUSE_RED, d[0]);
        write_reg(REG_DIFFUSE_GREEN, d[1]);
        write_reg(REG_DIFFUSE_BLUE, d[2]);
        write_reg(REG_SPECULAR_RED, sp[0]);
        write_reg(REG_SPECULAR_GREEN, sp[1]);
        write_reg(REG_SPECULAR_BLUE, sp[2]);
        write_reg(REG_SHININESS, n);
    endtask

    task automatic random_material();
        logic [15:0] d [3], sp [3];
        for (int i = 0; i < 3; i++) begin
            d[i]  = 16'($urandom);
            sp[i] = 16'($urandom);
        end
        load_material(d, sp, $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4095)));
    endtask

    function automatic logic signed [15:0] rnd_comp();
        return 16'($urandom_range(32768) - 16384);
    endfunction

    // mostly rays with both directions above the surface, some raw noise
    function automatic ray_t random_ray();
        ray_t   r;
        longint dn;
        for (int i = 0; i < 3; i++) begin
            r.nrm[i] = rnd_comp();
            r.wo[i]  = rnd_comp();
            r.wi[i]  = rnd_comp();
        end
        if ($urandom_range(99) < 75) begin
            if ($urandom_range(1)) begin
                // short vectors keep cos near one, where the lobe lives
                for (int i = 0; i < 3; i++) begin
                    r.nrm[i] = r.nrm[i] >>> 1;
                    r.wo[i]  = r.wo[i] >>> 1;
                    r.wi[i]  = r.wi[i] >>> 1;
                end
            end
            dn = dot16(r.wo, r.nrm);
            if (dn <= 0) for (int i = 0; i < 3; i++) r.wo[i] = -r.wo[i];
            dn = dot16(r.wi, r.nrm);
            if (dn <= 0) for (int i = 0; i < 3; i++) r.wi[i] = -r.wi[i];
            // now and then copy wi into wo
            if ($urandom_range(3) == 0) r.wo = r.wi;
        end
        return r;
    endfunction

    function automatic ray_t make_ray(int nx, ny, nz, ox, oy, oz, ix, iy, iz);
        ray_t r;
        r.nrm = '{16'(nx), 16'(ny), 16'(nz)};
        r.wo  = '{16'(ox), 16'(oy), 16'(oz)};
        r.wi  = '{16'(ix), 16'(iy), 16'(iz)};
        return r;
    endfunction

    // ---------------- tests ----------------

    task automatic test_reset_material();
        // all registers still zero: every output must be zero
        send_ray(make_ray(0, 0, 16384, 0, 0, 16384, 0, 0, 16384));
        send_ray(make_ray(0, 0, 16384, 8000, 0, 14000, -8000, 0, 14000));
        quiesce();
    endtask

    task automatic test_directed();
        logic [15:0] d [3] = '{16'd30000, 16'd65535, 16'd1};
        logic [15:0] sp [3] = '{16'd20000, 16'd0, 16'd65535};
        load_material(d, sp, 16'd640);
        write_reg(REG_UNUSED, 16'hFFFF);
        // straight-on: cos of lobe exactly one
        send_ray(make_ray(0, 0, 16384, 0, 0, 16384, 0, 0, 16384));
        // below surface on either side
        send_ray(make_ray(0, 0, 16384, 0, 0, -16384, 0, 0, 16384));
        send_ray(make_ray(0, 0, 16384, 0, 0, 16384, 0, 0, -16384));
        // right at the epsilon: dot 4 rejected, dot 8 accepted
        send_ray(make_ray(0, 0, 16384, 0, 0, 16384, 16384, 0, 1));
        send_ray(make_ray(0, 0, 16384, 0, 0, 16384, 16384, 0, 2));
        send_ray(make_ray(0, 0, 16384, 16384, 0, 2, 0, 0, 16384));
        // no lobe: grazing pair on the same side
        send_ray(make_ray(0, 0, 16384, 15000, 0, 6000, 15000, 0, 6000));
        // mirror pair: peak of the lobe
        send_ray(make_ray(0, 0, 16384, 8000, 3000, 14000, -8000, -3000, 14000));
        // unnormalized extremes: huge power
        send_ray(make_ray(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384));
        send_ray(make_ray(-16384, -16384, -16384, -16384, -16384, -16384,
                          -16384, -16384, -16384));
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_ray(make_ray(-16384, 0, 0, -16384, 0, 0, -1, 0, 0));
        quiesce();
        // exponent extremes
        write_reg(REG_SHININESS, 16'd0);
        send_ray(make_ray(0, 0, 16384, 8000, 3000, 14000, -8000, -3000, 14000));
        send_ray(make_ray(0, 0, 9000, 4000, 1000, 5000, -4000, 1000, 5000));
        quiesce();
        write_reg(REG_SHININESS, 16'hFFFF);
        send_ray(make_ray(0, 0, 16384, 8000, 3000, 14000, -8000, -3000, 14000));
        send_ray(make_ray(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384));
        send_ray(make_ray(0, 0, 16384, 0, 0, 16384, 0, 0, 16384));
        quiesce();
        // full scale material
        d  = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        sp = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        load_material(d, sp, 16'd64);
        send_ray(make_ray(0, 0, 16384, 8000, 3000, 14000, -8000, -3000, 14000));
        send_ray(make_ray(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384));
        quiesce();
    endtask

    task automatic test_random_phase(int sidle, int rstall, int count);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        random_material();
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                quiesce();
                random_material();
            end
            send_ray(random_ray());
        end
        quiesce();
    endtask

    // receiver holds off long enough that the pipeline fills and stalls input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_material();
        hold_req = HOLD_CYCLES;
        for (int i = 0; i < 200; i++) send_ray(random_ray());
        // sender pauses until the pipeline has drained
        quiesce();
        for (int i = 0; i < 50; i++) send_ray(random_ray());
        quiesce();
    endtask

    // ---------------- receiver, checker, watchdog ----------------

    always @(posedge aclk) begin
        if (hold_req > 0) begin
            m_tready <= 1'b0;
            hold_req <= hold_req - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        shade_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (shade_q.size() == 0) begin
                $error("result transaction with nothing expected: %h", m_tdata);
                n_fail++;
            end else begin
                want = shade_q.pop_front();
                if (m_tdata[23:0] !== want.red) begin
                    $error("reflect_red expected %h got %h", want.red, m_tdata[23:0]);
                    n_fail++;
                end
                if (m_tdata[47:24] !== want.green) begin
                    $error("reflect_green expected %h got %h", want.green, m_tdata[47:24]);
                    n_fail++;
                end
                if (m_tdata[71:48] !== want.blue) begin
                    $error("reflect_blue expected %h got %h", want.blue, m_tdata[71:48]);
                    n_fail++;
                end
                if (m_tdata[95:72] !== want.dens) begin
                    $error("sample_density expected %h got %h", want.dens, m_tdata[95:72]);
                    n_fail++;
                end
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        n_fail = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        kd = '{0, 0, 0};
        ks = '{0, 0, 0};
        shine = 0;
        refresh_weights();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_material();
        test_directed();
        test_random_phase(0, 0, 400);
        test_random_phase(50, 0, 400);
        test_random_phase(0, 50, 400);
        test_random_phase(9, 9, 400);
        test_backpressure();

        s_tvalid <= 1'b0;
        while (shade_q.size() != 0) @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
        if (n_fail == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
